// File: rtl/sirad_pkg.sv
// Package for the signed integer to radix digits block.
// Holds the sizes, codes and types shared by the digit row, its cells and the top level.
// Depends on nothing.
package sirad_pkg;

  localparam int CELLS     = 64;   // digit cells in the row
  localparam int MAG_BITS  = 63;   // magnitude bits after saturation
  localparam int DIGIT_W   = 4;
  localparam int RADIX_W   = 5;
  localparam int SYM_W     = 8;
  localparam int SYM_SLOTS = 16;
  localparam int MAX_RADIX = 16;
  localparam int CNT_W     = $clog2(CELLS);
  localparam int REG_W     = 64;
  localparam int ADDR_W    = 5;

  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_RADIX   = 2'd0;
  localparam logic [1:0] REG_SYM_LOW = 2'd1;
  localparam logic [1:0] REG_SYM_HI  = 2'd2;

  typedef logic [DIGIT_W-1:0] digit_t;

  // Data handed from one cell to the next in every conversion cycle.
  typedef struct packed {
    logic carry;   // doubling carry into the next digit
    logic en;      // a conversion step travels with this carry
    logic fin;     // this is the final conversion step
  } link_t;

  // Row control driven by the sequencer.
  typedef struct packed {
    logic clear;   // zero all digits and links for a new request
    logic conv;    // conversion phase: cells take steps from their links
    logic shift;   // emission: digits move one cell toward the top
  } row_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/signed_int_to_radix_digits_top.sv
// Top level of the signed integer to radix digits block.
// Holds the register port, the sequencer and the output register; depends on
// sirad_pkg, sirad_row and sirad_cell.
//
// Usage: each request on the in_ channel carries one signed 64-bit value in
// in_tdata. The block answers on the out_ channel with the text of that value
// in the configured radix, one symbol byte per transfer in out_tdata, with
// out_tlast high on the final symbol. A negative value starts with '-'. The
// radix and the sixteen symbol bytes are set over the cfg_ register port
// (radix at 0x0, symbols 0 to 7 at 0x8, symbols 8 to 15 at 0x10) while the
// block is idle. If the radix is below 2 or above 16, or a symbol in use is
// zero, '-' or '+', or two symbols in use are equal, the value is taken and
// dropped without any output.
// Flow: the magnitude enters a chain of 64 digit cells one bit per cycle,
// and each conversion step ripples up the chain one cell per cycle until the
// final step leaves the top cell. Emission then walks all 64 cells from the
// top, one cell per cycle while the receiver is ready, after a sign symbol
// for a negative value.
// A stalled receiver freezes emission; the last symbol sits in the output
// register while the next request is already accepted. Reset clears the
// registers, the sequencer and the output valid.
module signed_int_to_radix_digits_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel. in_tdata: [63:0] value.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // Result channel. out_tdata: [7:0] symbol. out_tlast marks the last symbol.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  // Register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [sirad_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import sirad_pkg::*;

  // Configuration registers.
  logic [RADIX_W-1:0] radix_r;
  logic [REG_W-1:0]   sym_low_r;
  logic [REG_W-1:0]   sym_high_r;
  logic [1:0]         reg_idx;
  logic               cfg_wr;

  // Sequencer state.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MAG_BITS-1:0] mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic               seen_r, seen_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]   out_sym_r, out_sym_nxt;
  logic               out_last_r, out_last_nxt;

  logic [2*REG_W-1:0] sym_all;
  logic [SYM_W-1:0]   sym_tab [SYM_SLOTS];
  logic               base_ok;
  logic               accept;
  logic               slot_free;
  logic               feeding;
  logic               last_cell;
  logic               show;
  row_ctl_t           row_ctl;
  link_t              feed;
  link_t              tail;
  digit_t             top_digit;
  logic [MAG_BITS-1:0] in_mag;

  // ---------------------------------------------------------------------------
  // Register port. Every access completes in its access cycle.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= '0;
      sym_low_r  <= '0;
      sym_high_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RADIX:   radix_r    <= cfg_pwdata[RADIX_W-1:0];
        REG_SYM_LOW: sym_low_r  <= cfg_pwdata;
        REG_SYM_HI:  sym_high_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RADIX:   cfg_prdata = {{(REG_W-RADIX_W){1'b0}}, radix_r};
      REG_SYM_LOW: cfg_prdata = sym_low_r;
      REG_SYM_HI:  cfg_prdata = sym_high_r;
      default:     cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Symbol table and base check. The checks on the sixteen slots are
  // independent compares, so the whole check settles in the accept cycle.
  // ---------------------------------------------------------------------------
  assign sym_all = {sym_high_r, sym_low_r};

  for (genvar s = 0; s < SYM_SLOTS; s++) begin : g_sym
    assign sym_tab[s] = sym_all[s*SYM_W +: SYM_W];
  end

  always_comb begin
    base_ok = (radix_r >= RADIX_W'(2)) && (radix_r <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < SYM_SLOTS; i++) begin
      if (RADIX_W'(i) < radix_r) begin
        if (sym_tab[i] == SYM_NUL || sym_tab[i] == SYM_MINUS || sym_tab[i] == SYM_PLUS) begin
          base_ok = 1'b0;
        end
        for (int j = 0; j < i; j++) begin
          if (sym_tab[j] == sym_tab[i]) begin
            base_ok = 1'b0;
          end
        end
      end
    end
  end

  // Magnitude with the most negative value saturated one step toward zero.
  always_comb begin
    if (in_tdata == {1'b1, {MAG_BITS{1'b0}}}) begin
      in_mag = {MAG_BITS{1'b1}};
    end else if (in_tdata[63]) begin
      in_mag = MAG_BITS'(~in_tdata + 64'd1);
    end else begin
      in_mag = in_tdata[MAG_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Digit row.
  // ---------------------------------------------------------------------------
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign slot_free = ~out_valid_r | out_tready;
  assign feeding   = (state_r == ST_CONV) && (cnt_r < CNT_W'(MAG_BITS));
  assign last_cell = (cnt_r == CNT_W'(CELLS-1));
  assign show      = seen_r | (top_digit != '0) | last_cell;

  // The magnitude enters cell 0 most significant bit first; the final bit
  // carries the fin mark, which tells the sequencer when it leaves the top cell.
  always_comb begin
    feed.carry = feeding & mag_r[MAG_BITS-1];
    feed.en    = feeding;
    feed.fin   = feeding && (cnt_r == CNT_W'(MAG_BITS-1));
  end

  sirad_row u_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (row_ctl),
    .radix    (radix_r),
    .feed     (feed),
    .tail     (tail),
    .top_digit(top_digit)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && base_ok) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (tail.fin) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free && last_cell) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs, counters and the output register.
  // ---------------------------------------------------------------------------
  always_comb begin
    row_ctl       = '0;
    cnt_nxt       = cnt_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    seen_nxt      = seen_r;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && base_ok) begin
          row_ctl.clear = 1'b1;
          cnt_nxt       = '0;
          mag_nxt       = in_mag;
          neg_nxt       = in_tdata[63];
          seen_nxt      = 1'b0;
        end
      end
      ST_CONV: begin
        row_ctl.conv = 1'b1;
        if (feeding) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          mag_nxt = {mag_r[MAG_BITS-2:0], 1'b0};
        end
        if (tail.fin) begin
          cnt_nxt = '0;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = SYM_MINUS;
          out_last_nxt  = 1'b0;
        end
      end
      ST_EMIT: begin
        // Leading zero digits are walked past without a result; the bottom
        // cell always yields one, so zero renders as the digit-0 symbol.
        if (slot_free) begin
          row_ctl.shift = 1'b1;
          cnt_nxt       = cnt_r + CNT_W'(1);
          seen_nxt      = show;
          if (show) begin
            out_valid_nxt = 1'b1;
            out_sym_nxt   = sym_tab[top_digit];
            out_last_nxt  = last_cell;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/sirad_cell.sv
// One radix digit cell: doubles its digit, adds the carry from its lower
// neighbor and reduces by the radix; shifts its digit upward during emission.
// Depends on sirad_pkg.
module sirad_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sirad_pkg::row_ctl_t               ctl,
  input  logic [sirad_pkg::RADIX_W-1:0]     radix,
  input  sirad_pkg::link_t                  link_in,
  output sirad_pkg::link_t                  link_out,
  input  sirad_pkg::digit_t                 digit_in,
  output sirad_pkg::digit_t                 digit_out
);
  import sirad_pkg::*;

  digit_t             digit_r, digit_nxt;
  link_t              link_r, link_nxt;
  logic [RADIX_W-1:0] sum;
  logic [RADIX_W-1:0] diff;
  logic               ge;

  // The digit stays below the radix, so twice it plus one fits in five bits.
  assign sum  = {digit_r, link_in.carry};
  assign ge   = (sum >= radix);
  assign diff = sum - radix;

  always_comb begin
    link_nxt.carry = link_in.en & ge;
    link_nxt.en    = link_in.en;
    link_nxt.fin   = link_in.en & link_in.fin;
  end

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.conv && link_in.en) begin
      digit_nxt = ge ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];
    end else if (ctl.shift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= '0;
    end else if (ctl.clear) begin
      link_r <= '0;
    end else if (ctl.conv) begin
      link_r <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign link_out  = link_r;
  assign digit_out = digit_r;

endmodule

// File: rtl/sirad_row.sv
// Row of radix digit cells, least significant digit in cell 0.
// Conversion links run upward one cell per cycle; emission shifts digits upward.
// Depends on sirad_pkg and sirad_cell.
module sirad_row (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sirad_pkg::row_ctl_t           ctl,
  input  logic [sirad_pkg::RADIX_W-1:0] radix,
  input  sirad_pkg::link_t              feed,
  output sirad_pkg::link_t              tail,
  output sirad_pkg::digit_t             top_digit
);
  import sirad_pkg::*;

  link_t  links  [CELLS+1];
  digit_t digits [CELLS+1];

  assign links[0]  = feed;
  assign digits[0] = '0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    sirad_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .radix    (radix),
      .link_in  (links[k]),
      .link_out (links[k+1]),
      .digit_in (digits[k]),
      .digit_out(digits[k+1])
    );
  end

  assign tail      = links[CELLS];
  assign top_digit = digits[CELLS];

endmodule

// File: rtl/sirad_chk.sv
// Port checker for the signed integer to radix digits block, bound to the top level.
// Depends on sirad_pkg and on the port names of signed_int_to_radix_digits_top.
module sirad_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  import sirad_pkg::*;

  // A stalled result holds its symbol and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The sign never ends a number, and no valid base emits a zero byte.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == SYM_MINUS |-> !out_tlast)
    else $error("minus sign marked last");

  a_no_nul: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != SYM_NUL)
    else $error("zero byte emitted");

  // While a number is still being emitted no new request is taken.
  a_busy_mid_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("request taken in the middle of a number");

endmodule

bind signed_int_to_radix_digits_top sirad_chk u_sirad_chk (.*);
